>>> src/uqpd_pkg.sv
// Shared types, codes and character helpers for the URL query pair decoder.
package uqpd_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [1:0] KindKey  = 2'd0;
  localparam logic [1:0] KindVal  = 2'd1;
  localparam logic [1:0] KindMark = 2'd2;

  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscPct   = 2'd1;
  localparam logic [1:0] EscDigit = 2'd2;

  localparam int MaxRes = 4;
  localparam int QDepth = 2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } uqpd_in_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] byte_out;
    logic       last_of_run;
  } uqpd_out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } uqpd_res_t;

  typedef struct packed {
    logic [$clog2(MaxRes)-1:0] last_idx;
    uqpd_res_t [MaxRes-1:0]    ent;
  } uqpd_bundle_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

>>> src/uqpd_decode.sv
// Pair and escape state with the decode logic that turns one byte into a result bundle.
module uqpd_decode (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire_i,
  input  uqpd_pkg::uqpd_in_t     item_i,
  output uqpd_pkg::uqpd_bundle_t bundle_o,
  output logic                   has_o
);

  logic       in_value_r, in_value_nxt;
  logic       pair_open_r, pair_open_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;

  logic [7:0] c;
  logic       hex;
  logic       f1_pct, f1_held, p_en, f2_pct, f2_held, mark;
  logic [7:0] p_byte;
  logic [1:0] esc_mid;
  logic [7:0] held_mid;
  logic       in_value_mid;
  logic [1:0] kind;
  logic [2:0] n;
  uqpd_pkg::uqpd_res_t [uqpd_pkg::MaxRes-1:0] ent;

  always_comb begin
    c            = item_i.char_in;
    hex          = uqpd_pkg::is_hex(c);
    f1_pct       = 1'b0;
    f1_held      = 1'b0;
    p_en         = 1'b0;
    p_byte       = c;
    f2_pct       = 1'b0;
    f2_held      = 1'b0;
    mark         = 1'b0;
    esc_mid      = esc_r;
    held_mid     = held_r;
    in_value_mid = in_value_r;
    in_value_nxt = in_value_r;
    pair_open_nxt = pair_open_r;
    esc_nxt      = esc_r;
    held_nxt     = held_r;

    if (c == uqpd_pkg::CharAmp) begin
      f1_pct        = (esc_r != uqpd_pkg::EscNone);
      f1_held       = (esc_r == uqpd_pkg::EscDigit);
      mark          = pair_open_r;
      in_value_nxt  = 1'b0;
      pair_open_nxt = 1'b0;
      esc_nxt       = uqpd_pkg::EscNone;
      held_nxt      = 8'd0;
    end else begin
      if (c == uqpd_pkg::CharEq && !in_value_r) begin
        f1_pct       = (esc_r != uqpd_pkg::EscNone);
        f1_held      = (esc_r == uqpd_pkg::EscDigit);
        esc_mid      = uqpd_pkg::EscNone;
        held_mid     = 8'd0;
        in_value_mid = 1'b1;
      end else if (esc_r == uqpd_pkg::EscPct && hex) begin
        esc_mid  = uqpd_pkg::EscDigit;
        held_mid = c;
      end else if (esc_r == uqpd_pkg::EscDigit && hex) begin
        p_en     = 1'b1;
        p_byte   = {uqpd_pkg::hex_val(held_r), uqpd_pkg::hex_val(c)};
        esc_mid  = uqpd_pkg::EscNone;
        held_mid = 8'd0;
      end else begin
        f1_pct   = (esc_r != uqpd_pkg::EscNone);
        f1_held  = (esc_r == uqpd_pkg::EscDigit);
        held_mid = 8'd0;
        if (c == uqpd_pkg::CharPct) begin
          esc_mid = uqpd_pkg::EscPct;
        end else begin
          esc_mid = uqpd_pkg::EscNone;
          p_en    = 1'b1;
          p_byte  = (c == uqpd_pkg::CharPlus) ? uqpd_pkg::CharSpace : c;
        end
      end
      if (item_i.end_of_string) begin
        f2_pct        = (esc_mid != uqpd_pkg::EscNone);
        f2_held       = (esc_mid == uqpd_pkg::EscDigit);
        mark          = 1'b1;
        in_value_nxt  = 1'b0;
        pair_open_nxt = 1'b0;
        esc_nxt       = uqpd_pkg::EscNone;
        held_nxt      = 8'd0;
      end else begin
        in_value_nxt  = in_value_mid;
        pair_open_nxt = 1'b1;
        esc_nxt       = esc_mid;
        held_nxt      = held_mid;
      end
    end
  end

  // Every data byte of one item belongs to the part that was open when it arrived.
  always_comb begin
    kind = in_value_r ? uqpd_pkg::KindVal : uqpd_pkg::KindKey;
    n    = 3'd0;
    ent  = '0;
    if (f1_pct) begin
      ent[n[1:0]] = '{kind: kind, data: uqpd_pkg::CharPct};
      n = n + 3'd1;
    end
    if (f1_held) begin
      ent[n[1:0]] = '{kind: kind, data: held_r};
      n = n + 3'd1;
    end
    if (p_en) begin
      ent[n[1:0]] = '{kind: kind, data: p_byte};
      n = n + 3'd1;
    end
    if (f2_pct) begin
      ent[n[1:0]] = '{kind: kind, data: uqpd_pkg::CharPct};
      n = n + 3'd1;
    end
    if (f2_held) begin
      ent[n[1:0]] = '{kind: kind, data: held_mid};
      n = n + 3'd1;
    end
    if (mark) begin
      ent[n[1:0]] = '{kind: uqpd_pkg::KindMark, data: 8'd0};
      n = n + 3'd1;
    end
  end

  assign has_o             = (n != 3'd0);
  assign bundle_o.ent      = ent;
  assign bundle_o.last_idx = 2'(n - 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r  <= 1'b0;
      pair_open_r <= 1'b0;
      esc_r       <= uqpd_pkg::EscNone;
      held_r      <= 8'd0;
    end else if (fire_i) begin
      in_value_r  <= in_value_nxt;
      pair_open_r <= pair_open_nxt;
      esc_r       <= esc_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

>>> src/uqpd_queue.sv
// Two-deep queue of result bundles that hands out one result item per cycle while out_ready is high.
module uqpd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  uqpd_pkg::uqpd_bundle_t bundle_i,
  output logic                   space_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output uqpd_pkg::uqpd_out_t    out_data
);

  localparam int PtrW = $clog2(uqpd_pkg::QDepth);
  localparam int CntW = $clog2(uqpd_pkg::QDepth + 1);
  localparam int SubW = $clog2(uqpd_pkg::MaxRes);

  uqpd_pkg::uqpd_bundle_t q_r [uqpd_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [SubW-1:0] sub_r;
  uqpd_pkg::uqpd_bundle_t head;
  uqpd_pkg::uqpd_res_t    cur;
  logic last, take, pop;

  assign head      = q_r[rd_ptr_r];
  assign cur       = head.ent[sub_r];
  assign last      = (sub_r == head.last_idx);
  assign out_valid = (cnt_r != '0);
  assign space_o   = (cnt_r != CntW'(uqpd_pkg::QDepth));
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  assign out_data.item_kind   = cur.kind;
  assign out_data.byte_out    = cur.data;
  assign out_data.last_of_run = last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push_i) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= bundle_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(uqpd_pkg::QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(uqpd_pkg::QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (take) begin
        sub_r <= last ? '0 : sub_r + SubW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(uqpd_pkg::QDepth))
    else $error("bundle count beyond queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> space_o)
    else $error("bundle pushed into a full queue");

  a_sub_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sub_r <= head.last_idx))
    else $error("result index runs past its bundle");

  a_sub_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (sub_r == '0))
    else $error("result index not cleared with empty queue");

endmodule

>>> src/url_query_pair_decoder_core.sv
// Top level of the URL query pair decoder: input register, decode stage and result queue.
// Path: an item's results pass the input register and then the result queue before they are
// offered, and a full result queue holds the item in the input register.
// Throughput: one item per cycle while each item yields at most one result and out_ready
// is high; an item's further results hold the output, and the two-bundle queue sets the stall.
// Reset: synchronous active-low rst_n empties the pipeline and returns the pair state to key.
module url_query_pair_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uqpd_pkg::uqpd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uqpd_pkg::uqpd_out_t out_data
);

  logic                   in_valid_r, in_valid_nxt;
  uqpd_pkg::uqpd_in_t     in_data_r;
  logic                   space, fire, has;
  uqpd_pkg::uqpd_bundle_t bundle;

  assign fire         = in_valid_r && space;
  assign in_ready     = !in_valid_r || fire;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  uqpd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (fire),
    .item_i   (in_data_r),
    .bundle_o (bundle),
    .has_o    (has)
  );

  uqpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (fire && has),
    .bundle_i  (bundle),
    .space_o   (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
